// File: design/dip_pkg.sv
package dip_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned OCTET_W   = 9;
  localparam int unsigned DOTS_W    = 2;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0]  CHAR_DOT  = 8'h2E;

  localparam logic [OCTET_W-1:0] OCTET_MAX = 9'd255;
  localparam logic [OCTET_W-1:0] OCTET_SAT = 9'd256;

  localparam logic [DOTS_W-1:0]  DOTS_FULL = 2'd3;

endpackage

// File: design/dotted_ipv4_text_parser_core.sv
// Dotted-decimal IPv4 text parser.
//
// Input stream (in_*): one ASCII character per transaction in in_tdata,
// in_tlast marks the final character of an address text. Digits build the
// current octet, '.' closes it, anything else is skipped.
// Output stream (out_*): one transaction per text, issued for the last
// character only: out_tdata is the address (first octet in bits 31..24),
// out_tuser is the malformed flag; when set, out_tdata carries the
// default address register instead of the parsed value.
// Config: cfg_we writes cfg_wdata into the default address register.
//
// Throughput is one character per cycle: the octet multiply-by-ten add and
// the dot placement sit between the input handshake and the result register.
// out_tvalid rises in the cycle after the last character is accepted.
// A stalled result holds in the output register; characters keep being
// taken while out_tready is high or the register is empty.
// Reset (rst_n low, synchronous) clears the parse state, the output valid
// and the default address register.
module dotted_ipv4_text_parser_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [dip_pkg::CHAR_W-1:0] in_tdata,   // [7:0] text_char
  input  logic                       in_tlast,   // is_last
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dip_pkg::ADDR_W-1:0] out_tdata,  // [31:0] address
  output logic                       out_tuser,  // [0] malformed
  input  logic                       cfg_we,
  input  logic [dip_pkg::ADDR_W-1:0] cfg_wdata
);
  import dip_pkg::*;

  localparam int unsigned PROD_W = OCTET_W + 3;

  logic [OCTET_W-1:0] octet_r, octet_nxt;
  logic [DOTS_W-1:0]  dots_r, dots_nxt;
  logic [ADDR_W-1:0]  part_r, part_nxt;
  logic               err_r, err_nxt;
  logic [ADDR_W-1:0]  default_r;
  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic               out_bad_r, out_bad_nxt;

  logic               accept;
  logic               is_digit;
  logic               is_dot;
  logic [PROD_W-1:0]  prod;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_bad_r;

  always_comb begin
    is_digit = in_tdata inside {[CHAR_ZERO:CHAR_NINE]};
    is_dot   = (in_tdata == CHAR_DOT);
    // octet * 10 + digit; low nibble of '0'..'9' is the digit value
    prod = ({3'b000, octet_r} << 3) + ({3'b000, octet_r} << 1)
           + {{(PROD_W-4){1'b0}}, in_tdata[3:0]};

    octet_nxt = octet_r;
    dots_nxt  = dots_r;
    part_nxt  = part_r;
    err_nxt   = err_r;

    if (is_digit) begin
      octet_nxt = (prod > PROD_W'(OCTET_MAX)) ? OCTET_SAT : prod[OCTET_W-1:0];
    end else if (is_dot) begin
      if (octet_r > OCTET_MAX || dots_r == DOTS_FULL) begin
        err_nxt = 1'b1;
      end else begin
        case (dots_r)
          2'd0:    part_nxt = part_r | {octet_r[7:0], 24'h000000};
          2'd1:    part_nxt = part_r | {8'h00, octet_r[7:0], 16'h0000};
          2'd2:    part_nxt = part_r | {16'h0000, octet_r[7:0], 8'h00};
          default: part_nxt = part_r;
        endcase
        dots_nxt = dots_r + 2'd1;
      end
      octet_nxt = '0;
    end

    out_bad_nxt  = err_nxt || (dots_nxt != DOTS_FULL) || (octet_nxt > OCTET_MAX);
    out_addr_nxt = out_bad_nxt ? default_r : (part_nxt | {24'h000000, octet_nxt[7:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octet_r     <= '0;
      dots_r      <= '0;
      part_r      <= '0;
      err_r       <= 1'b0;
      default_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        default_r <= cfg_wdata;
      end
      if (accept && in_tlast) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        if (in_tlast) begin
          // emit result, start the next text from a clean state
          out_addr_r  <= out_addr_nxt;
          out_bad_r   <= out_bad_nxt;
          octet_r     <= '0;
          dots_r      <= '0;
          part_r      <= '0;
          err_r       <= 1'b0;
        end else begin
          octet_r <= octet_nxt;
          dots_r  <= dots_nxt;
          part_r  <= part_nxt;
          err_r   <= err_nxt;
        end
      end
    end
  end

endmodule

// File: design/dip_checker.sv
module dip_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       in_tlast,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [dip_pkg::ADDR_W-1:0] out_tdata,
  input logic                       out_tuser
);
  import dip_pkg::*;

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output transaction changed");

  // a new result only follows an accepted last character
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast))
    else $error("output transaction without a last character");

  // a non-last character never produces a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> !out_tvalid)
    else $error("result issued for a non-last character");

  // input back-pressure only comes from a stalled output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output is free");

endmodule

bind dotted_ipv4_text_parser_core dip_checker u_dip_checker (.*);

// File: sim/tb.sv
module tb;
  import dip_pkg::*;

  localparam int TOP_SHIFT = 24;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              malformed;
  } parse_result_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    bit                last;
    bit                typed;
    parse_result_t     want;
  } text_row_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [CHAR_W-1:0] in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [ADDR_W-1:0] out_tdata;
  logic              out_tuser;
  logic              cfg_we     = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata  = '0;

  dotted_ipv4_text_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor state
  logic [OCTET_W-1:0] octet_acc   = '0;
  logic [DOTS_W-1:0]  dots_closed = '0;
  logic [ADDR_W-1:0]  addr_acc    = '0;
  bit                 text_bad    = 1'b0;
  logic [ADDR_W-1:0]  default_addr = '0;

  parse_result_t     awaited_addresses[$];
  logic [CHAR_W-1:0] text_buf[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int chars_sent = 0;
  int texts_done = 0;
  int texts_malformed = 0;
  int phase_chars = 0;

  // directed texts: "255..9." with the dot as last character, ".<FF>.<00>.256",
  // "....", "7", "300..."
  text_row_t directed_rows[26] = '{
    '{"2", 1'b0, 1'b0, '0}, '{"5", 1'b0, 1'b0, '0}, '{"5", 1'b0, 1'b0, '0},
    '{CHAR_DOT, 1'b0, 1'b0, '0}, '{CHAR_DOT, 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{CHAR_DOT, 1'b1, 1'b1, '{32'hFF00_0900, 1'b0}},
    '{CHAR_DOT, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{CHAR_DOT, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{CHAR_DOT, 1'b0, 1'b0, '0},
    '{"2", 1'b0, 1'b0, '0}, '{"5", 1'b0, 1'b0, '0},
    '{"6", 1'b1, 1'b1, '{32'h0000_0000, 1'b1}},
    '{CHAR_DOT, 1'b0, 1'b0, '0}, '{CHAR_DOT, 1'b0, 1'b0, '0},
    '{CHAR_DOT, 1'b0, 1'b0, '0},
    '{CHAR_DOT, 1'b1, 1'b1, '{32'h0000_0000, 1'b1}},
    '{"7", 1'b1, 1'b1, '{32'h0000_0000, 1'b1}},
    '{"3", 1'b0, 1'b0, '0}, '{"0", 1'b0, 1'b0, '0}, '{"0", 1'b0, 1'b0, '0},
    '{CHAR_DOT, 1'b0, 1'b0, '0}, '{CHAR_DOT, 1'b0, 1'b0, '0},
    '{CHAR_DOT, 1'b1, 1'b1, '{32'h0000_0000, 1'b1}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit is_digit(input logic [CHAR_W-1:0] ch);
    return ch >= CHAR_ZERO && ch <= CHAR_NINE;
  endfunction

  function automatic bit parse_step(input logic [CHAR_W-1:0] ch, input bit last,
                                    output parse_result_t res);
    int unsigned next;
    bit bad;
    res = '0;
    if (is_digit(ch)) begin
      next = octet_acc * 10 + (ch - CHAR_ZERO);
      octet_acc = (next > OCTET_MAX) ? OCTET_SAT : OCTET_W'(next);
    end else if (ch == CHAR_DOT) begin
      if (octet_acc > OCTET_MAX || dots_closed == DOTS_FULL) begin
        text_bad = 1'b1;
      end else begin
        addr_acc |= ADDR_W'(octet_acc[7:0]) << (TOP_SHIFT - CHAR_W * dots_closed);
        dots_closed++;
      end
      octet_acc = '0;
    end
    if (!last) return 1'b0;
    bad = text_bad || dots_closed != DOTS_FULL || octet_acc > OCTET_MAX;
    res.address   = bad ? default_addr : (addr_acc | ADDR_W'(octet_acc[7:0]));
    res.malformed = bad;
    octet_acc   = '0;
    dots_closed = '0;
    addr_acc    = '0;
    text_bad    = 1'b0;
    return 1'b1;
  endfunction

  // Present one character, hold it until accepted, then predict its result.
  task automatic feed_char(input logic [CHAR_W-1:0] ch, input bit last,
                           input bit typed, input parse_result_t typed_res);
    parse_result_t res;
    bit got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    phase_chars++;
    got = parse_step(ch, last, res);
    if (got) begin
      if (typed) res = typed_res;
      awaited_addresses.insert(awaited_addresses.size(), res);
      texts_done++;
      if (res.malformed) texts_malformed++;
    end
  endtask

  function automatic void append_char(input logic [CHAR_W-1:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  function automatic void push_decimal(input int value, input int pad);
    string s;
    s = $sformatf("%0d", value);
    repeat (pad) append_char(CHAR_ZERO);
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endfunction

  function automatic logic [CHAR_W-1:0] noise_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255)); while (is_digit(c) || c == CHAR_DOT);
    return c;
  endfunction

  task automatic send_random_text();
    int kind;
    int pick;
    int n_oct;
    kind = $urandom_range(0, 99);
    text_buf.delete();
    if (kind < 70) begin
      // well-formed: four octets, some empty, padded or sprinkled with junk
      for (int k = 0; k < 4; k++) begin
        if (k != 0) append_char(CHAR_DOT);
        pick = $urandom_range(0, 9);
        if (pick != 2)
          push_decimal(pick == 0 ? 0 : pick == 1 ? 255 : $urandom_range(0, 255),
                       $urandom_range(0, 7) == 0 ? $urandom_range(1, 2) : 0);
        if ($urandom_range(0, 9) == 0) append_char(noise_char());
      end
    end else if (kind < 88) begin
      // random dot count, octets sometimes oversized; mostly malformed
      n_oct = $urandom_range(1, 6);
      for (int k = 0; k < n_oct; k++) begin
        if (k != 0) append_char(CHAR_DOT);
        push_decimal($urandom_range(0, 3) == 0 ? $urandom_range(256, 99999)
                                               : $urandom_range(0, 255), 0);
      end
      if ($urandom_range(0, 3) == 0) append_char(CHAR_DOT);
    end else begin
      repeat ($urandom_range(1, 6)) append_char(CHAR_W'($urandom_range(0, 255)));
    end
    foreach (text_buf[i]) feed_char(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (awaited_addresses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_default(input logic [ADDR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    default_addr = value;
  endtask

  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_addresses.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h/%b",
                 $time, out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = awaited_addresses.pop_front();
        if (out_tdata !== want.address) begin
          $display("%0t: address mismatch, expected %h actual %h",
                   $time, want.address, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.malformed) begin
          $display("%0t: malformed flag mismatch, expected %b actual %b",
                   $time, want.malformed, out_tuser);
          fail_count++;
        end
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] phase_default[3];
    int phase_send[3];
    int phase_recv[3];
    phase_default = '{32'hFFFF_FFFF, $urandom, 32'h0000_0000};
    phase_send    = '{31, 46, 0};
    phase_recv    = '{46, 31, 0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = phase_send[0];
    recv_idle_pct = phase_recv[0];
    // default register is still at its reset value here
    foreach (directed_rows[i])
      feed_char(directed_rows[i].ch, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].want);
    drain();
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = phase_send[p];
      recv_idle_pct = phase_recv[p];
      write_default(phase_default[p]);
      phase_chars = 0;
      while (phase_chars < 410) send_random_text();
      drain();
    end
    if (awaited_addresses.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_addresses.size());
      fail_count++;
    end
    $display("Sent %0d characters forming %0d texts, %0d of them malformed,",
             chars_sent, texts_done, texts_malformed);
    $display("under three pacing mixes and four default-address settings.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
design/dip_pkg.sv
design/dotted_ipv4_text_parser_core.sv
design/dip_checker.sv
sim/tb.sv
